FILE: rtl/core/pvbpm_pkg.sv
// pvbpm_pkg: shared constants, types and cordic table for the pv bus mismatch block
// no dependencies
`default_nettype none
package pvbpm_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = 5;

  localparam logic signed [39:0] AccMax = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] AccMin = 40'sh80_0000_0000;
  localparam logic signed [27:0] PiQ24 = 28'sd52707179;
  localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [27:0] TwoPiQ24 = 28'sd105414357;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSQ,
    ST_SHUNT,
    ST_ROT,
    ST_GC,
    ST_BS,
    ST_VV,
    ST_TERM
  } state_e;

  // arctangent table, q.24
  function automatic logic [23:0] atan_q24(input logic [StepW-1:0] i);
    logic [23:0] r;
    begin
      case (i)
        5'd0: r = 24'd13176795;
        5'd1: r = 24'd7778716;
        5'd2: r = 24'd4110060;
        5'd3: r = 24'd2086331;
        5'd4: r = 24'd1047214;
        5'd5: r = 24'd524117;
        5'd6: r = 24'd262123;
        5'd7: r = 24'd131069;
        default: r = 24'd65536 >> (i - 5'd8);
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pvbpm_cordic.sv
// pvbpm_cordic: iterative cordic rotation giving cos and sin in q.14
// depends on pvbpm_pkg
`default_nettype none
module pvbpm_cordic
  import pvbpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] angle_i,
  output logic               done_o,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [27:0] z_q, z_d;
  logic               neg_q, neg_d;
  logic [StepW-1:0]   i_q, i_d;
  logic               busy_q, busy_d;
  logic               done_q;
  logic signed [27:0] z0, z1;
  logic signed [33:0] dx, dy;
  logic signed [27:0] at;
  logic signed [17:0] cr, sr;

  // wrap into [-pi, pi] then fold into [-pi/2, pi/2]
  always_comb begin
    z0 = 28'(angle_i) <<< 11;
    if (z0 > PiQ24) z0 = z0 - TwoPiQ24;
    else if (z0 < -PiQ24) z0 = z0 + TwoPiQ24;
    z1 = z0;
    if (z0 > HalfPiQ24) z1 = z0 - PiQ24;
    else if (z0 < -HalfPiQ24) z1 = z0 + PiQ24;
  end

  // one rotation step per cycle
  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = 28'(atan_q24(i_q));
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; busy_d = busy_q; neg_d = neg_q;
    if (start_i) begin
      x_d = GainQ30; y_d = '0; z_d = z1; i_d = '0; busy_d = 1'b1;
      neg_d = (z0 > HalfPiQ24) || (z0 < -HalfPiQ24);
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
      end
      i_d = i_q + 1'b1;
      if (i_q == StepW'(CordicSteps - 1)) busy_d = 1'b0;
    end
  end

  // done pulses once the last rotation has been stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      i_q <= i_d;
      done_q <= busy_q && !busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; neg_q <= neg_d;
  end

  // round to q.14 and apply fold sign
  always_comb begin
    cr = 18'((x_q + 34'sd32768) >>> 16);
    sr = 18'((y_q + 34'sd32768) >>> 16);
    cos_o = neg_q ? -cr[15:0] : cr[15:0];
    sin_o = neg_q ? -sr[15:0] : sr[15:0];
  end
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: rtl/core/pv_bus_power_mismatch.sv
// pv_bus_power_mismatch: pv bus active power and angle residual, top level
// depends on pvbpm_pkg and pvbpm_cordic
//
// usage: one input word per line attached to a bus, first_of_node_i marks the
// word that carries the bus fields, last_of_node_i the word that ends the bus.
// a bus with no lines is one word with far_voltage_i zero.
// both channels use valid and stall; a word is taken when valid is high and
// stall low. in_stall_o is high while a word is being worked on.
// a word runs cordic rotation until done, with the voltage product taken
// meanwhile in ST_ROT, then the cos, sin and term products through one
// shared multiplier in ST_GC, ST_BS and ST_VV, and the term add in ST_TERM.
// a first word first passes ST_VSQ and ST_SHUNT for v*v and the shunt term.
// the residual word is valid in the cycle the block turns ready again and is
// held in an output register until taken; while the receiver stalls it, no
// new word is taken.
// reset clears the sum, held bus voltage, angle, angle error and overflow flag to zero.
`default_nettype none
module pv_bus_power_mismatch
  import pvbpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        node_voltage_i,
  input  logic signed [15:0] node_angle_i,
  input  logic signed [23:0] node_conductance_i,
  input  logic signed [31:0] power_setpoint_i,
  input  logic signed [15:0] angle_setpoint_i,
  input  logic [15:0]        far_voltage_i,
  input  logic signed [15:0] far_angle_i,
  input  logic signed [23:0] line_conductance_i,
  input  logic signed [23:0] line_susceptance_i,
  input  logic               line_entering_i,
  input  logic               first_of_node_i,
  input  logic               last_of_node_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [39:0] power_residual_o,
  output logic signed [16:0] angle_residual_o,
  output logic               saturated_o
);

  state_e state_q, state_d;
  logic signed [39:0] sum_q, sum_d;
  logic [15:0] volt_q;
  logic signed [15:0] ang_q;
  logic signed [16:0] aerr_q;
  logic ovf_q, ovf_d;
  logic signed [31:0] pset_q;
  logic signed [23:0] g_q, gl_q, bl_q;
  logic [15:0] vk_q;
  logic signed [15:0] ak_q;
  logic ent_q, last_q;
  logic signed [58:0] prod_q;
  logic signed [47:0] mix_q;
  logic signed [33:0] vv_q;
  logic ovalid_q;
  logic signed [39:0] pr_q;
  logic signed [16:0] ar_q;
  logic sat_q;
  logic take, cstart, cdone;
  logic signed [16:0] dang;
  logic signed [15:0] c, s;
  logic signed [24:0] mixr;
  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [58:0] mul;
  logic signed [63:0] addv;
  logic signed [41:0] wide;

  assign take = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (ovalid_q && out_stall_i);

  pvbpm_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i(cstart), .angle_i(dang), .done_o(cdone), .cos_o(c), .sin_o(s)
  );

  // far angle straight from the port on the accepting edge, held afterwards
  assign dang = 17'(ang_q) - 17'((state_q == ST_IDLE) ? far_angle_i : ak_q);

  // shared multiplier, one product per cycle
  always_comb begin
    mixr = 25'((mix_q + 48'sd8192) >>> 14);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_VSQ: begin
        mul_a = signed'({9'd0, volt_q});
        mul_b = signed'({18'd0, volt_q});
      end
      ST_SHUNT: begin
        mul_a = 25'(g_q);
        mul_b = prod_q[33:0];
      end
      ST_ROT: begin
        mul_a = signed'({9'd0, volt_q});
        mul_b = signed'({18'd0, vk_q});
      end
      ST_GC: begin
        mul_a = 25'(gl_q);
        mul_b = 34'(c);
      end
      ST_BS: begin
        mul_a = 25'(bl_q);
        mul_b = 34'(s);
      end
      ST_VV: begin
        mul_a = mixr;
        mul_b = vv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul = 59'(mul_a) * 59'(mul_b);
  end

  // saturating add into the sum
  always_comb begin
    wide = 42'(sum_q) + 42'(addv);
    sum_d = sum_q;
    ovf_d = ovf_q;
    if (wide > 42'(AccMax)) begin
      sum_d = AccMax; ovf_d = 1'b1;
    end else if (wide < 42'(AccMin)) begin
      sum_d = AccMin; ovf_d = 1'b1;
    end else sum_d = wide[39:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cstart = 1'b0;
    addv = '0;
    case (state_q)
      ST_IDLE: if (take) state_d = first_of_node_i ? ST_VSQ : ST_ROT;
      ST_VSQ: state_d = ST_SHUNT;
      ST_SHUNT: begin
        addv = ((64'(mul) + 64'sd134217728) >>> 28) - 64'(pset_q);
        state_d = ST_ROT;
      end
      ST_ROT: if (cdone) state_d = ST_GC;
      ST_GC: state_d = ST_BS;
      ST_BS: state_d = ST_VV;
      ST_VV: state_d = ST_TERM;
      ST_TERM: begin
        addv = (64'(prod_q) + 64'sd134217728) >>> 28;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && take) cstart = !first_of_node_i;
    if (state_q == ST_SHUNT) cstart = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q <= '0; volt_q <= '0; ang_q <= '0; aerr_q <= '0; ovf_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && take && first_of_node_i) begin
        volt_q <= node_voltage_i;
        ang_q <= node_angle_i;
        aerr_q <= 17'(node_angle_i) - 17'(angle_setpoint_i);
        ovf_q <= 1'b0;
        sum_q <= '0;
      end else begin
        sum_q <= sum_d;
        ovf_q <= ovf_d;
      end
      if (state_q == ST_TERM && last_q) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && take) begin
      g_q <= node_conductance_i; pset_q <= power_setpoint_i;
      vk_q <= far_voltage_i; ak_q <= far_angle_i;
      gl_q <= line_conductance_i; bl_q <= line_susceptance_i;
      ent_q <= line_entering_i; last_q <= last_of_node_i;
    end
    if (state_q == ST_VSQ || state_q == ST_VV) prod_q <= mul;
    if (state_q == ST_ROT && cdone) vv_q <= 34'(mul);
    if (state_q == ST_GC) mix_q <= 48'(mul);
    if (state_q == ST_BS) mix_q <= ent_q ? mix_q - 48'(mul) : mix_q + 48'(mul);
    if (state_q == ST_TERM && last_q) begin
      pr_q <= sum_d; ar_q <= aerr_q; sat_q <= ovf_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign power_residual_o = pr_q;
  assign angle_residual_o = ar_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking bench for pv_bus_power_mismatch, directed table then random buses
// depends on pvbpm_pkg and the pv_bus_power_mismatch rtl
`default_nettype none
module tb_top
  import pvbpm_pkg::*;
;

  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    logic [15:0]        vn;
    logic signed [15:0] an;
    logic signed [23:0] gn;
    logic signed [31:0] pset;
    logic signed [15:0] aset;
    logic [15:0]        vk;
    logic signed [15:0] ak;
    logic signed [23:0] gl;
    logic signed [23:0] bl;
    logic               ent;
    logic               first;
    logic               last;
  } line_word_t;

  typedef struct {
    logic signed [39:0] pres;
    logic signed [16:0] ares;
    logic               sat;
  } residual_t;

  // directed row: word plus an optional typed-in residual
  typedef struct {
    line_word_t w;
    logic       known;
    residual_t  r;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [15:0] node_voltage_i, far_voltage_i;
  logic signed [15:0] node_angle_i, angle_setpoint_i, far_angle_i;
  logic signed [23:0] node_conductance_i, line_conductance_i, line_susceptance_i;
  logic signed [31:0] power_setpoint_i;
  logic line_entering_i, first_of_node_i, last_of_node_i;
  logic signed [39:0] power_residual_o;
  logic signed [16:0] angle_residual_o;
  logic saturated_o;

  pv_bus_power_mismatch DUT (.*);

  // predictor state
  longint bus_sum;
  int unsigned bus_v;
  int bus_ang, bus_aerr;
  bit bus_ovf;
  residual_t residual_q[$];
  int errors;
  int send_idle, recv_idle;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    return fshift(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint atan_entry(int i);
    longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                     131069};
    if (i < 8) return t[i];
    return longint'(65536) >>> (i - 8);
  endfunction

  // sine and cosine in q.14 by rotation, angle difference in q3.13
  task automatic cordic_sincos(input longint d, output longint c, output longint s);
    longint z, x, y, dx, dy, sgn;
    int n;
    z = d * 2048;
    x = 652032874;
    y = 0;
    sgn = 1;
    n = (CordicSteps > 24) ? 24 : CordicSteps;
    while (z > 52707179) z -= 105414357;
    while (z < -52707179) z += 105414357;
    if (z > 26353589) begin
      z -= 52707179; sgn = -1;
    end else if (z < -26353589) begin
      z += 52707179; sgn = -1;
    end
    for (int i = 0; i < n; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = sgn * round_q(x, 16);
    s = sgn * round_q(y, 16);
  endtask

  function automatic void add_clamped(longint a);
    longint t;
    t = bus_sum + a;
    if (t > 64'sd549755813887) begin
      t = 64'sd549755813887; bus_ovf = 1;
    end
    if (t < -64'sd549755813888) begin
      t = -64'sd549755813888; bus_ovf = 1;
    end
    bus_sum = t;
  endfunction

  // advance the bus model by one word; returns 1 when a residual is due
  task automatic predict_word(input line_word_t w, output bit emits, output residual_t r);
    longint c, s, mix;
    if (w.first) begin
      bus_v = w.vn;
      bus_ang = w.an;
      bus_aerr = int'(w.an) - int'(w.aset);
      bus_ovf = 0;
      bus_sum = 0;
      add_clamped(-longint'(w.pset) + round_q(longint'(w.gn) * w.vn * w.vn, 28));
    end
    cordic_sincos(longint'(bus_ang) - longint'(w.ak), c, s);
    mix = w.ent ? longint'(w.gl) * c - longint'(w.bl) * s
                : longint'(w.gl) * c + longint'(w.bl) * s;
    mix = round_q(mix, 14);
    add_clamped(round_q(longint'(bus_v) * longint'(w.vk) * mix, 28));
    emits = w.last;
    r.pres = bus_sum[39:0];
    r.ares = bus_aerr[16:0];
    r.sat = bus_ovf;
  endtask

  // drive one word and wait until it is taken; valid stays up for a word that follows
  task automatic send_word(input line_word_t w);
    bit emits;
    residual_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    node_voltage_i <= w.vn;
    node_angle_i <= w.an;
    node_conductance_i <= w.gn;
    power_setpoint_i <= w.pset;
    angle_setpoint_i <= w.aset;
    far_voltage_i <= w.vk;
    far_angle_i <= w.ak;
    line_conductance_i <= w.gl;
    line_susceptance_i <= w.bl;
    line_entering_i <= w.ent;
    first_of_node_i <= w.first;
    last_of_node_i <= w.last;
    predict_word(w, emits, r);
    if (emits) residual_q.push_back(r);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic line_word_t rand_word(bit first, bit last);
    line_word_t w;
    w.vn = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(14000, 18000));
    w.an = 16'($urandom);
    w.gn = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
    w.pset = 32'($urandom);
    w.aset = 16'($urandom);
    w.vk = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(14000, 18000));
    w.ak = 16'($urandom);
    w.gl = 24'($urandom);
    w.bl = 24'($urandom);
    w.ent = 1'($urandom);
    w.first = first;
    w.last = last;
    return w;
  endfunction

  function automatic row_t mk(line_word_t w);
    row_t x;
    x.w = w;
    x.known = 0;
    x.r = '{0, 0, 0};
    return x;
  endfunction

  // receiver: random stall, check against oldest residual
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
      if (out_valid_o && !out_stall_i) begin
        if (residual_q.size() == 0) begin
          $error("residual word with nothing expected");
          errors++;
        end else begin
          residual_t e;
          e = residual_q.pop_front();
          if (power_residual_o !== e.pres) begin
            $error("power_residual exp %0d got %0d", e.pres, power_residual_o);
            errors++;
          end
          if (angle_residual_o !== e.ares) begin
            $error("angle_residual exp %0d got %0d", e.ares, angle_residual_o);
            errors++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated exp %0d got %0d", e.sat, saturated_o);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("[pv_bus_power_mismatch] ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    line_word_t w;
    residual_t tr;
    int nlines;
    errors = 0;
    quiet_cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    node_voltage_i = '0; node_angle_i = '0; node_conductance_i = '0;
    power_setpoint_i = '0; angle_setpoint_i = '0; far_voltage_i = '0;
    far_angle_i = '0; line_conductance_i = '0; line_susceptance_i = '0;
    line_entering_i = 1'b0; first_of_node_i = 1'b0; last_of_node_i = 1'b0;
    bus_sum = 0; bus_v = 0; bus_ang = 0; bus_aerr = 0; bus_ovf = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    // word straight after reset with held state zero: everything zero
    w = rand_word(0, 1); w.ak = 16'sd1000;
    rows.push_back('{w, 1'b1, '{40'sd0, 17'sd0, 1'b0}});
    // bus without lines, zero shunt: residual is minus setpoint
    w = rand_word(1, 1); w.vk = 0; w.gn = 0; w.pset = 32'sh0001_0000;
    w.an = 16'sd100; w.aset = 16'sd40;
    rows.push_back('{w, 1'b1, '{-40'sd65536, 17'sd60, 1'b0}});
    // angle extremes give residual extremes
    w = rand_word(1, 1); w.vk = 0; w.gn = 0; w.pset = 0;
    w.an = 16'sh7FFF; w.aset = 16'sh8000;
    rows.push_back('{w, 1'b1, '{40'sd0, 17'sd65535, 1'b0}});
    w.an = 16'sh8000; w.aset = 16'sh7FFF;
    rows.push_back('{w, 1'b1, '{40'sd0, -17'sd65535, 1'b0}});
    // maximum voltages, conductances and setpoints
    w = rand_word(1, 0); w.vn = 16'hFFFF; w.gn = 24'sh7FFFFF; w.pset = 32'sh8000_0000;
    w.vk = 16'hFFFF; w.gl = 24'sh7FFFFF; w.bl = 24'sh7FFFFF; w.ent = 0; w.ak = 16'sh8000;
    rows.push_back(mk(w));
    w.first = 0; w.ent = 1; w.bl = 24'sh800000; w.gl = 24'sh800000;
    rows.push_back(mk(w));
    // several largest positive terms on a long bus
    for (int i = 0; i < 6; i++) begin
      w.first = 0; w.last = (i == 5); w.gl = 24'sh7FFFFF; w.bl = 24'sh7FFFFF;
      w.ak = w.an; w.ent = 0;
      rows.push_back(mk(w));
    end
    // largest negative terms on the next bus
    w = rand_word(1, 0); w.vn = 16'hFFFF; w.gn = 24'sh800000; w.pset = 32'sh7FFF_FFFF;
    w.vk = 16'hFFFF; w.gl = 24'sh800000; w.ak = w.an; w.ent = 1;
    rows.push_back(mk(w));
    for (int i = 0; i < 5; i++) begin
      w.first = 0; w.last = (i == 4);
      rows.push_back(mk(w));
    end
    w = rand_word(1, 1); w.vk = 0; w.gn = 0; w.pset = 0; w.an = 0; w.aset = 0;
    rows.push_back('{w, 1'b1, '{40'sd0, 17'sd0, 1'b0}});
    // angles near +/- pi, entering and leaving
    w = rand_word(1, 0); w.an = 16'sd25736; w.ak = -16'sd25736; w.ent = 0;
    rows.push_back(mk(w));
    w.first = 0; w.last = 1; w.ent = 1; w.ak = 16'sd0;
    rows.push_back(mk(w));
    // word with neither flag continuing a finished bus
    w = rand_word(0, 0);
    rows.push_back(mk(w));
    w = rand_word(0, 1);
    rows.push_back(mk(w));

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].known && residual_q.size() > 0) begin
        tr = residual_q[$];
        if (tr.pres !== rows[i].r.pres) begin
          $error("table row %0d: power_residual exp %0d got %0d", i, rows[i].r.pres,
                 tr.pres);
          errors++;
        end
        if (tr.ares !== rows[i].r.ares) begin
          $error("table row %0d: angle_residual exp %0d got %0d", i, rows[i].r.ares,
                 tr.ares);
          errors++;
        end
        if (tr.sat !== rows[i].r.sat) begin
          $error("table row %0d: saturated exp %0d got %0d", i, rows[i].r.sat, tr.sat);
          errors++;
        end
      end
    end

    // random buses in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 7 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 7 : 0;
      for (int k = 0; k < 600;) begin
        if ($urandom_range(19) == 0) begin
          send_word(rand_word(1'($urandom), 1'($urandom)));
          k++;
        end else begin
          nlines = $urandom_range(4) == 0 ? 1 : $urandom_range(2, 6);
          for (int j = 0; j < nlines; j++) begin
            w = rand_word(j == 0, j == nlines - 1);
            if (nlines == 1 && $urandom_range(1)) w.vk = 0;
            send_word(w);
            k++;
          end
        end
      end
    end
    in_valid_i <= 1'b0;
    recv_idle = 0;

    while (residual_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0)
      $display("[pv_bus_power_mismatch] OK");
    else
      $display("[pv_bus_power_mismatch] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
